// ----- rtl/core/flk_pkg.sv -----
// Shared types, constants and helper functions of the flicker PWM block.
`default_nettype none

package flk_pkg;

  // Field widths.
  localparam int unsigned LFSR_W   = 16;
  localparam int unsigned DUTY_W   = 8;
  localparam int unsigned DELAY_W  = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_TDATA_W = 8;
  localparam int unsigned OUT_TDATA_W = 24;

  // Default wait span between draws, in milliseconds.
  localparam int unsigned DELAY_SPAN_DEF = 50;

  // Reset duty of both lamps and reset value of the minimum duty.
  localparam logic [DUTY_W-1:0] RESET_DUTY = 8'd50;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED     = 1'b1;

  // Per-transaction control from the top level to the datapath units.
  typedef struct packed {
    logic acc_ms;   // accepted item carries a millisecond tick
    logic acc_pwm;  // accepted item carries a PWM tick
    logic draw;     // millisecond tick with the wait run out: draw new values
  } flk_ctl_t;

  // One step of the Fibonacci LFSR (taps 15, 14, 12, 3); zero is replaced by one.
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] s0;
    logic              fb;
    s0 = (s == '0) ? LFSR_W'(1) : s;
    fb = s0[15] ^ s0[14] ^ s0[12] ^ s0[3];
    return {s0[LFSR_W-2:0], fb};
  endfunction

  // Value mod 255, then raised to the minimum duty. The byte sum is
  // congruent to the value mod 255 and stays below 511.
  function automatic logic [DUTY_W-1:0] duty_from(input logic [LFSR_W-1:0] x,
                                                  input logic [DUTY_W-1:0] min_d);
    logic [DUTY_W:0]   sum;
    logic [DUTY_W:0]   red;
    logic [DUTY_W-1:0] d;
    sum = {1'b0, x[15:8]} + {1'b0, x[7:0]};
    red = (sum >= 9'd255) ? (sum - 9'd255) : sum;
    d   = (red == 9'd255) ? '0 : red[DUTY_W-1:0];
    return (d < min_d) ? min_d : d;
  endfunction

endpackage : flk_pkg

`default_nettype wire

// ----- rtl/core/flk_rng.sv -----
// Random source: LFSR state, minimum duty register and the three-step draw.
`default_nettype none

module flk_rng (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [flk_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [flk_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire flk_pkg::flk_ctl_t              ctl,
  output logic [flk_pkg::DUTY_W-1:0]          new_duty_a,
  output logic [flk_pkg::DUTY_W-1:0]          new_duty_b,
  output logic [flk_pkg::LFSR_W-1:0]          wait_raw
);
  import flk_pkg::*;

  logic [LFSR_W-1:0] lfsr_r;
  logic [DUTY_W-1:0] min_duty_r;
  logic [LFSR_W-1:0] step1;
  logic [LFSR_W-1:0] step2;
  logic [LFSR_W-1:0] step3;

  // Three chained steps: duty A, duty B, then the new wait.
  always_comb begin
    step1      = lfsr_step(lfsr_r);
    step2      = lfsr_step(step1);
    step3      = lfsr_step(step2);
    new_duty_a = duty_from(step1, min_duty_r);
    new_duty_b = duty_from(step2, min_duty_r);
    wait_raw   = step3;
  end

  // Configuration writes load the registers; a draw advances the LFSR.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r     <= LFSR_W'(1);
      min_duty_r <= RESET_DUTY;
    end else if (cfg_we) begin
      if (cfg_idx == REG_MIN_DUTY) begin
        min_duty_r <= cfg_wdata[DUTY_W-1:0];
      end else begin
        lfsr_r <= (cfg_wdata[LFSR_W-1:0] == '0) ? LFSR_W'(1) : cfg_wdata[LFSR_W-1:0];
      end
    end else if (ctl.draw) begin
      lfsr_r <= step3;
    end
  end

endmodule : flk_rng

`default_nettype wire

// ----- rtl/core/flk_delay.sv -----
// Wait counter between draws, with the modulo reduction split over the register.
`default_nettype none

module flk_delay #(
  parameter int unsigned DELAY_SPAN = flk_pkg::DELAY_SPAN_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire flk_pkg::flk_ctl_t         ctl,
  input  wire logic [flk_pkg::LFSR_W-1:0] wait_raw,
  output logic                           wait_done
);
  import flk_pkg::*;

  // Reciprocal with a 24-bit fraction; exact for 16-bit values and spans below 256.
  localparam int unsigned FRAC_W  = 24;
  localparam int unsigned RECIP_I = ((1 << FRAC_W) + DELAY_SPAN - 1) / DELAY_SPAN;
  localparam logic [FRAC_W:0]       RECIP = (FRAC_W + 1)'(RECIP_I);
  localparam logic [DELAY_W-1:0]    SPAN  = DELAY_W'(DELAY_SPAN);
  localparam int unsigned PROD_W = LFSR_W + FRAC_W + 1;

  logic [DELAY_W-1:0]        delay_left_r;
  logic [DELAY_W-1:0]        delay_left_nxt;
  logic [FRAC_W-1:0]         frac_r;
  logic                      frac_vld_r;
  logic [PROD_W-1:0]         recip_prod;
  logic [FRAC_W+DELAY_W-1:0] rem_prod;
  logic [DELAY_W-1:0]        delay_eff;

  // The fraction of wait_raw / span, times the span, gives the remainder.
  always_comb begin
    recip_prod = PROD_W'(wait_raw) * PROD_W'(RECIP);
    rem_prod   = (FRAC_W + DELAY_W)'(frac_r) * (FRAC_W + DELAY_W)'(SPAN);
    delay_eff  = frac_vld_r ? rem_prod[FRAC_W+DELAY_W-1:FRAC_W] : delay_left_r;
    wait_done  = (delay_eff == '0);
    delay_left_nxt = delay_eff - DELAY_W'(1);
  end

  // A draw stores the fraction; a plain tick folds it in and counts down.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_left_r <= '0;
      frac_vld_r   <= 1'b0;
    end else if (ctl.acc_ms) begin
      if (ctl.draw) begin
        frac_vld_r <= 1'b1;
      end else begin
        delay_left_r <= delay_left_nxt;
        frac_vld_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.draw) begin
      frac_r <= recip_prod[FRAC_W-1:0];
    end
  end

endmodule : flk_delay

`default_nettype wire

// ----- rtl/core/flk_pwm.sv -----
// Fast-PWM counter with pending and active duties of both lamps.
`default_nettype none

module flk_pwm (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire flk_pkg::flk_ctl_t          ctl,
  input  wire logic [flk_pkg::DUTY_W-1:0] new_duty_a,
  input  wire logic [flk_pkg::DUTY_W-1:0] new_duty_b,
  output logic                            lamp_a_nxt,
  output logic                            lamp_b_nxt,
  output logic [flk_pkg::DUTY_W-1:0]      duty_a_nxt,
  output logic [flk_pkg::DUTY_W-1:0]      duty_b_nxt
);
  import flk_pkg::*;

  logic [DUTY_W-1:0] cnt_r;
  logic [DUTY_W-1:0] cnt_nxt;
  logic [DUTY_W-1:0] pend_a_r;
  logic [DUTY_W-1:0] pend_b_r;
  logic [DUTY_W-1:0] pend_a_nxt;
  logic [DUTY_W-1:0] pend_b_nxt;
  logic [DUTY_W-1:0] act_a_r;
  logic [DUTY_W-1:0] act_b_r;

  // Pending duties take a draw first; a wrap then copies them to active.
  always_comb begin
    pend_a_nxt = ctl.draw ? new_duty_a : pend_a_r;
    pend_b_nxt = ctl.draw ? new_duty_b : pend_b_r;
    cnt_nxt    = ctl.acc_pwm ? (cnt_r + DUTY_W'(1)) : cnt_r;
    if (ctl.acc_pwm && (cnt_nxt == '0)) begin
      duty_a_nxt = pend_a_nxt;
      duty_b_nxt = pend_b_nxt;
    end else begin
      duty_a_nxt = act_a_r;
      duty_b_nxt = act_b_r;
    end
    lamp_a_nxt = (cnt_nxt <= duty_a_nxt);
    lamp_b_nxt = (cnt_nxt <= duty_b_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      pend_a_r <= RESET_DUTY;
      pend_b_r <= RESET_DUTY;
      act_a_r  <= RESET_DUTY;
      act_b_r  <= RESET_DUTY;
    end else begin
      cnt_r    <= cnt_nxt;
      pend_a_r <= pend_a_nxt;
      pend_b_r <= pend_b_nxt;
      act_a_r  <= duty_a_nxt;
      act_b_r  <= duty_b_nxt;
    end
  end

endmodule : flk_pwm

`default_nettype wire

// ----- rtl/core/lfsr_flicker_two_channel_pwm.sv -----
// Top level of the two-lamp LFSR flicker PWM generator.
//
//   Channel  | Direction | Handshake            | Contents
//   ---------+-----------+----------------------+---------------------------------
//   in_      | input     | in_tvalid/in_tready  | timer ticks (ms_tick, pwm_tick)
//   out_     | output    | out_tvalid/out_tready| lamp levels, active duties, flag
//   cfg_     | input     | cfg_valid/cfg_ready  | min_duty (0), seed (1)
//
// One transaction per cycle is sustained while out_tready stays high.
// The state update (three LFSR steps, duty reduction, wait counter, PWM counter)
// is done in the accept cycle; the result sits in an output register in the next cycle.
// in_tready stays high while the output register is empty or being drained.
// Reset is synchronous and active low; no clearing pass is needed.
`default_nettype none

module lfsr_flicker_two_channel_pwm #(
  parameter int unsigned DELAY_SPAN = flk_pkg::DELAY_SPAN_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input stream.
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [flk_pkg::IN_TDATA_W-1:0]    in_tdata,   // [0] ms_tick, [1] pwm_tick
  // Result stream.
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [flk_pkg::OUT_TDATA_W-1:0]        out_tdata,  // [0] lamp_a, [1] lamp_b,
                                                             // [9:2] duty_a, [17:10] duty_b,
                                                             // [18] updated
  // Configuration writes.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [flk_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [flk_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import flk_pkg::*;

  flk_ctl_t          ctl;
  logic              in_acc;
  logic              cfg_we;
  logic              wait_done;
  logic [DUTY_W-1:0] new_duty_a;
  logic [DUTY_W-1:0] new_duty_b;
  logic [LFSR_W-1:0] wait_raw;
  logic              lamp_a_nxt;
  logic              lamp_b_nxt;
  logic [DUTY_W-1:0] duty_a_nxt;
  logic [DUTY_W-1:0] duty_b_nxt;
  logic              out_vld_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // Handshakes.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid;
  assign in_tready = !out_vld_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    ctl.acc_ms  = in_acc && in_tdata[0];
    ctl.acc_pwm = in_acc && in_tdata[1];
    ctl.draw    = ctl.acc_ms && wait_done;
  end

  flk_rng u_rng (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_index),
    .cfg_wdata  (cfg_data),
    .ctl        (ctl),
    .new_duty_a (new_duty_a),
    .new_duty_b (new_duty_b),
    .wait_raw   (wait_raw)
  );

  flk_delay #(
    .DELAY_SPAN (DELAY_SPAN)
  ) u_delay (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .wait_raw  (wait_raw),
    .wait_done (wait_done)
  );

  flk_pwm u_pwm (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .new_duty_a (new_duty_a),
    .new_duty_b (new_duty_b),
    .lamp_a_nxt (lamp_a_nxt),
    .lamp_b_nxt (lamp_b_nxt),
    .duty_a_nxt (duty_a_nxt),
    .duty_b_nxt (duty_b_nxt)
  );

  // Output register: valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (in_acc) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  // Output register: payload, loaded with the state after the accepted item.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= {5'b0, ctl.draw, duty_b_nxt, duty_a_nxt, lamp_b_nxt, lamp_a_nxt};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule : lfsr_flicker_two_channel_pwm

`default_nettype wire

// ----- rtl/core/flk_checker.sv -----
// Port-level checks of the flicker PWM block and their binding to the top level.
`default_nettype none

module flk_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic [flk_pkg::IN_TDATA_W-1:0] in_tdata,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [flk_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed while stalled");

  // Every accepted tick transaction produces a result in the next cycle.
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> out_tvalid)
    else $error("accepted transaction gave no result");

  // A full, stalled output register blocks new input.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input accepted over a stalled result");

  // Without a PWM tick the active duties cannot change.
  a_duty_steady: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tdata[1] && out_tvalid)
      |=> (out_tdata[17:2] == $past(out_tdata[17:2])))
    else $error("active duty changed without a PWM tick");

  // Full duty keeps a lamp on.
  a_full_duty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[9:2] == 8'hFF)) |-> out_tdata[0])
    else $error("lamp A off at full duty");

endmodule : flk_checker

bind lfsr_flicker_two_channel_pwm flk_checker u_flk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
